[sv/pst_pkg.sv]
// Package: shared constants and types for the polyline stroke block.
`timescale 1ns / 1ps
`default_nettype none
package pst_pkg;
  localparam int MAX_POLYGONS_DEF    = 65536;
  localparam int MAX_VERTICES_DEF    = 65536;
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int UNIT_BITS           = 30;
  localparam int CORNERS             = 6;
  localparam int CFG_TARGET_CLASS    = 0;
  localparam int CFG_LINE_WIDTH      = 1;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_SQX  = 11'b00000000010,
    ST_SQY  = 11'b00000000100,
    ST_SQS  = 11'b00000001000,
    ST_SQRT = 11'b00000010000,
    ST_DIVX = 11'b00000100000,
    ST_DIVY = 11'b00001000000,
    ST_MULX = 11'b00010000000,
    ST_MULY = 11'b00100000000,
    ST_HALF = 11'b01000000000,
    ST_EMIT = 11'b10000000000
  } state_e;
endpackage
`default_nettype wire

[sv/polyline_segment_to_hexagon.sv]
// Top level: polyline vertex stream to stroked hexagon corners.
// Steps: squares, square root, divides for x and y, offsets, then corner emit;
// a short segment skips the square root and divides. Passthrough is registered.
// Throughput: one item per cycle for passthrough and first vertices while the
// output is free; a segment holds the input until its sixth corner is taken.
// Reset clears control state only; target class resets to -1, stroke width 1.0.
`timescale 1ns / 1ps
`default_nettype none
module polyline_segment_to_hexagon #(
  parameter int MAX_POLYGONS    = pst_pkg::MAX_POLYGONS_DEF,
  parameter int MAX_VERTICES    = pst_pkg::MAX_VERTICES_DEF,
  parameter int COORD_FRAC_BITS = pst_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // x_coord[31:0], y_coord[63:32], vertex_cls[71:64]
  input  wire logic [71:0]  s_axis_tdata_i,
  // first_vertex[0], new_example[1]
  input  wire logic [1:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // out_x[31:0], out_y[63:32], polygon_index[79:64], point_index[95:80],
  // out_class[103:96]
  output logic [103:0]      m_axis_tdata_o,
  output logic              m_axis_tlast_o,
  input  wire logic         psel_i,
  input  wire logic         penable_i,
  input  wire logic         pwrite_i,
  input  wire logic [2:0]   paddr_i,
  input  wire logic [31:0]  pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);
  import pst_pkg::*;

  localparam int PCW = (MAX_POLYGONS > 2) ? $clog2(MAX_POLYGONS) : 1;
  localparam int VCW = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam longint EPS_RAW = ((64'sd1 <<< COORD_FRAC_BITS) + 500) / 1000;
  localparam longint EPS = (EPS_RAW > 0) ? EPS_RAW : 1;
  localparam logic [63:0] EPS2 = 64'(EPS * EPS);

  logic [8:0]  target_q;
  logic [31:0] lw_q;
  state_e      st_q;
  logic [31:0] prev_x_q, prev_y_q;
  logic [PCW-1:0] pcnt_q, pidx_q;
  logic [VCW-1:0] vord_q;
  logic [7:0]  pclass_q;
  logic        pstroke_q;

  logic signed [35:0] sx_q, sy_q, ex_q, ey_q;
  logic [31:0] axs_q, ays_q;
  logic        negx_q, negy_q, s0_q;
  logic [63:0] prod_q, sqacc_q;
  logic [63:0] v_q, r_q, bit_q;
  logic [31:0] len_q;
  logic [32:0] rem_q;
  logic [30:0] nlo_q, quo_q, qx_q, qy_q;
  logic [4:0]  cnt_q;
  logic [33:0] hx_q, hy_q;
  logic [2:0]  k_q;
  logic        ov_q;
  logic [103:0] od_q;
  logic        ol_q;

  logic        cfg_wr, in_acc, slot_free, first, newex, stroke_now, ov_set;
  logic [31:0] in_x, in_y;
  logic [7:0]  in_cls;
  logic signed [32:0] dx, dy;
  logic [32:0] ax, ay;
  logic [1:0]  sh;
  logic [31:0] mul_a, mul_b;
  logic [63:0] sq, rb;
  logic [32:0] trial;
  logic [62:0] num;
  logic [31:0] lenc;
  logic signed [35:0] odx, ody, bx, by, ofx, ofy, sumx, sumy;
  logic [PCW-1:0] pcnt_base, pcnt_inc;
  logic [31:0] pad_p, pad_i, pad_v;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'h7fffffff;
    if (v < -36'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  assign in_x   = s_axis_tdata_i[31:0];
  assign in_y   = s_axis_tdata_i[63:32];
  assign in_cls = s_axis_tdata_i[71:64];
  assign first  = s_axis_tuser_i[0];
  assign newex  = s_axis_tuser_i[1];
  assign cfg_wr = psel_i & penable_i & pwrite_i & pready_o;
  assign pready_o = 1'b1;
  assign prdata_o = paddr_i[2] ? lw_q : {23'd0, target_q};

  assign slot_free = !ov_q || m_axis_tready_i;
  assign s_axis_tready_o = (st_q == ST_IDLE) && slot_free;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign stroke_now = first ? (target_q == {1'b0, in_cls}) : pstroke_q;
  assign ov_set = (in_acc && !stroke_now) || ((st_q == ST_EMIT) && slot_free);
  assign pcnt_base = (first && newex) ? '0 : pcnt_q;
  assign pcnt_inc = (pcnt_base == PCW'(MAX_POLYGONS - 1)) ? '0 : pcnt_base + 1'b1;

  assign dx = $signed({in_x[31], in_x}) - $signed({prev_x_q[31], prev_x_q});
  assign dy = $signed({in_y[31], in_y}) - $signed({prev_y_q[31], prev_y_q});
  assign ax = dx[32] ? 33'(-dx) : dx;
  assign ay = dy[32] ? 33'(-dy) : dy;
  always_comb begin
    if (ax[32] || ay[32]) sh = 2'd2;
    else if (ax[31] || ay[31]) sh = 2'd1;
    else sh = 2'd0;
  end

  always_comb begin
    case (st_q)
      ST_SQX:  begin mul_a = axs_q; mul_b = axs_q; end
      ST_SQY:  begin mul_a = ays_q; mul_b = ays_q; end
      ST_MULX: begin mul_a = lw_q; mul_b = {1'b0, qx_q}; end
      ST_MULY: begin mul_a = lw_q; mul_b = {1'b0, qy_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sq    = sqacc_q + prod_q;
  assign rb    = r_q + bit_q;
  assign trial = {rem_q[31:0], nlo_q[30]};
  assign lenc  = (r_q[31:0] == 32'd0) ? 32'd1 : r_q[31:0];
  assign num   = ({31'd0, (len_q == 32'd0) ? axs_q : ays_q} << UNIT_BITS)
               + {32'd0, lenc[31:1]};

  assign odx = negx_q ? -$signed({2'b00, hx_q}) : $signed({2'b00, hx_q});
  assign ody = negy_q ? -$signed({2'b00, hy_q}) : $signed({2'b00, hy_q});
  always_comb begin
    case (k_q)
      3'd0: begin bx = sx_q; by = sy_q; ofx = -ody; ofy = odx;  end
      3'd1: begin bx = ex_q; by = ey_q; ofx = -ody; ofy = odx;  end
      3'd2: begin bx = ex_q; by = ey_q; ofx = odx;  ofy = ody;  end
      3'd3: begin bx = ex_q; by = ey_q; ofx = ody;  ofy = -odx; end
      3'd4: begin bx = sx_q; by = sy_q; ofx = ody;  ofy = -odx; end
      default: begin bx = sx_q; by = sy_q; ofx = -odx; ofy = -ody; end
    endcase
  end
  assign sumx = bx + ofx;
  assign sumy = by + ofy;
  assign pad_p = 32'(pcnt_q);
  assign pad_i = 32'(first ? pcnt_base : pidx_q);
  assign pad_v = 32'(first ? '0 : vord_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= 9'h1ff;
      lw_q <= 32'(64'd1 << COORD_FRAC_BITS);
      st_q <= ST_IDLE;
      prev_x_q <= '0; prev_y_q <= '0;
      pcnt_q <= '0; pidx_q <= '0; vord_q <= '0;
      pclass_q <= '0; pstroke_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr_i[2] == 1'(CFG_LINE_WIDTH)) lw_q <= pwdata_i;
        else target_q <= pwdata_i[8:0];
      end
      if (ov_set) ov_q <= 1'b1;
      else if (m_axis_tready_i) ov_q <= 1'b0;
      case (st_q)
        ST_IDLE: begin
          if (in_acc) begin
            prev_x_q <= in_x; prev_y_q <= in_y;
            vord_q <= (first || vord_q == VCW'(MAX_VERTICES - 1)) ?
                      ((first && MAX_VERTICES > 1) ? VCW'(1) : '0) : vord_q + 1'b1;
            if (first) begin
              pclass_q <= in_cls;
              pstroke_q <= stroke_now;
              pcnt_q <= stroke_now ? pcnt_base : pcnt_inc;
              if (!stroke_now) pidx_q <= pcnt_base;
            end
            if (!stroke_now) begin
              ol_q <= 1'b1;
              od_q <= {first ? in_cls : pclass_q, pad_v[15:0], pad_i[15:0], in_y, in_x};
            end else if (!first) begin
              sx_q <= 36'($signed(prev_x_q)); sy_q <= 36'($signed(prev_y_q));
              ex_q <= 36'($signed(in_x));     ey_q <= 36'($signed(in_y));
              axs_q <= 32'(ax >> sh); ays_q <= 32'(ay >> sh);
              negx_q <= dx[32]; negy_q <= dy[32]; s0_q <= (sh == 2'd0);
              st_q <= ST_SQX;
            end
          end
        end
        ST_SQX: begin prod_q <= mul_a * mul_b; st_q <= ST_SQY; end
        ST_SQY: begin sqacc_q <= prod_q; prod_q <= mul_a * mul_b; st_q <= ST_SQS; end
        ST_SQS: begin
          if (s0_q && sq < EPS2) begin
            qx_q <= 31'(64'd1 << UNIT_BITS); qy_q <= '0;
            negx_q <= 1'b0; negy_q <= 1'b0;
            ex_q <= sx_q + 36'(EPS); ey_q <= sy_q;
            st_q <= ST_MULX;
          end else begin
            v_q <= sq; r_q <= '0; bit_q <= 64'd1 << 62; cnt_q <= '0;
            st_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (v_q >= rb) begin
            v_q <= v_q - rb; r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 1'b1;
          if (bit_q == 64'd1) begin
            len_q <= '0;
            st_q <= ST_DIVX;
          end
        end
        ST_DIVX, ST_DIVY: begin
          if (len_q == 32'd0) begin
            len_q <= lenc;
            rem_q <= {1'b0, num[62:31]};
            nlo_q <= num[30:0];
            cnt_q <= '0;
          end else if (cnt_q == 5'd30) begin
            if (st_q == ST_DIVX) begin
              qx_q <= {quo_q[29:0], trial >= {1'b0, len_q}};
              rem_q <= {1'b0, num[62:31]};
              nlo_q <= num[30:0];
              cnt_q <= '0;
              st_q <= ST_DIVY;
            end else begin
              qy_q <= {quo_q[29:0], trial >= {1'b0, len_q}};
              st_q <= ST_MULX;
            end
          end else begin
            if (trial >= {1'b0, len_q}) begin
              rem_q <= trial - {1'b0, len_q}; quo_q <= {quo_q[29:0], 1'b1};
            end else begin
              rem_q <= trial; quo_q <= {quo_q[29:0], 1'b0};
            end
            nlo_q <= nlo_q << 1;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MULX: begin prod_q <= mul_a * mul_b; st_q <= ST_MULY; end
        ST_MULY: begin
          hx_q <= 34'((prod_q + (64'd1 << UNIT_BITS)) >> (UNIT_BITS + 1));
          prod_q <= mul_a * mul_b;
          k_q <= '0;
          st_q <= ST_HALF;
        end
        ST_HALF: begin
          hy_q <= 34'((prod_q + (64'd1 << UNIT_BITS)) >> (UNIT_BITS + 1));
          st_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            ol_q <= (k_q == 3'(CORNERS - 1));
            od_q <= {pclass_q, 13'd0, k_q, pad_p[15:0], sat32(sumy), sat32(sumx)};
            k_q <= k_q + 1'b1;
            if (k_q == 3'(CORNERS - 1)) begin
              pcnt_q <= (pcnt_q == PCW'(MAX_POLYGONS - 1)) ? '0 : pcnt_q + 1'b1;
              st_q <= ST_IDLE;
            end
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tlast_o  = ol_q;
endmodule
`default_nettype wire

[sv/pst_checker.sv]
// Checker: port-level properties of the stroke block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pst_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic [103:0] m_axis_tdata_o,
  input wire logic         m_axis_tlast_o,
  input wire logic         pready_o
);
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled item changed");
  a_corner_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tdata_o[95:80] <= 16'd4)
    else $error("non-final corner index out of range");
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o)
    else $error("input taken while corners pending");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready low");
endmodule

bind polyline_segment_to_hexagon pst_checker u_pst_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tlast_o(m_axis_tlast_o),
  .pready_o(pready_o)
);
`default_nettype wire

[verif/polyline_segment_to_hexagon_tb.sv]
// Testbench for the polyline stroke block: directed and random vertex streams checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

class hex_scoreboard;
  bit [8:0]  tgt_class;
  bit [31:0] stroke_w;
  longint    last_x, last_y;
  bit [15:0] poly_cnt, pass_idx, vtx_ord;
  bit [7:0]  cur_class;
  bit        cur_stroke;
  bit [104:0] pending[$];
  int        errors;

  function new();
    tgt_class = 9'h1ff;
    stroke_w = 32'h10000;
    last_x = 0;
    last_y = 0;
    poly_cnt = 0;
    pass_idx = 0;
    vtx_ord = 0;
    cur_class = 0;
    cur_stroke = 0;
    errors = 0;
  endfunction

  function bit [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function longint root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function longint to_unit(longint num, longint unsigned den);
    longint unsigned m, q;
    m = (num < 0) ? -num : num;
    q = ((m << 30) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function longint half_off(longint u);
    longint unsigned m, p, q;
    m = (u < 0) ? -u : u;
    p = longint'(stroke_w) * m;
    q = (p + (64'd1 << 30)) >> 31;
    return (u < 0) ? -longint'(q) : longint'(q);
  endfunction

  function void add_corner(longint x, longint y, bit [15:0] pt, bit lst);
    pending.push_back({lst, cur_class, pt, poly_cnt, clamp32(y), clamp32(x)});
  endfunction

  function void note_vertex(bit [31:0] xr, bit [31:0] yr, bit [7:0] cls, bit first,
                            bit newex);
    longint x, y, sx, sy, ex, ey, dx, dy, ux, uy, odx, ody, otx, oty, dxs, dys;
    longint unsigned ax, ay, sq, len;
    int s;
    x = longint'(signed'(xr));
    y = longint'(signed'(yr));
    if (first) begin
      if (newex) poly_cnt = 0;
      cur_class = cls;
      cur_stroke = (longint'(signed'(tgt_class)) == longint'(cls));
      vtx_ord = 0;
      if (!cur_stroke) begin
        pass_idx = poly_cnt;
        poly_cnt = poly_cnt + 1;
      end
    end
    if (!cur_stroke) begin
      pending.push_back({1'b1, cur_class, vtx_ord, pass_idx, yr, xr});
    end else if (!first) begin
      sx = last_x; sy = last_y; ex = x; ey = y;
      dx = ex - sx; dy = ey - sy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      s = 0;
      while ((ax >> s) >= (64'd1 << 31) || (ay >> s) >= (64'd1 << 31)) s++;
      sq = (ax >> s) * (ax >> s) + (ay >> s) * (ay >> s);
      if (s == 0 && sq < 64'd4356) begin
        // short segment: unit x direction, end nudged by eps (66 steps)
        ux = 64'sd1 << 30;
        uy = 0;
        ex = sx + 66;
        ey = sy;
      end else begin
        len = root64(sq);
        dxs = (dx < 0) ? -longint'(ax >> s) : longint'(ax >> s);
        dys = (dy < 0) ? -longint'(ay >> s) : longint'(ay >> s);
        if (len == 0) len = 1;
        ux = to_unit(dxs, len);
        uy = to_unit(dys, len);
      end
      odx = half_off(ux);
      ody = half_off(uy);
      otx = -ody;
      oty = odx;
      add_corner(sx + otx, sy + oty, 0, 0);
      add_corner(ex + otx, ey + oty, 1, 0);
      add_corner(ex + odx, ey + ody, 2, 0);
      add_corner(ex - otx, ey - oty, 3, 0);
      add_corner(sx - otx, sy - oty, 4, 0);
      add_corner(sx - odx, sy - ody, 5, 1);
      poly_cnt = poly_cnt + 1;
    end
    last_x = x;
    last_y = y;
    vtx_ord = vtx_ord + 1;
  endfunction

  function void check_corner(bit [103:0] data, bit lst);
    bit [104:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected item got data=%h last=%b", $realtime, data, lst);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (want[31:0] != data[31:0])
      $display("%0t: out_x expected %h got %h", $realtime, want[31:0], data[31:0]);
    if (want[63:32] != data[63:32])
      $display("%0t: out_y expected %h got %h", $realtime, want[63:32], data[63:32]);
    if (want[79:64] != data[79:64])
      $display("%0t: polygon_index expected %0d got %0d", $realtime, want[79:64],
               data[79:64]);
    if (want[95:80] != data[95:80])
      $display("%0t: point_index expected %0d got %0d", $realtime, want[95:80],
               data[95:80]);
    if (want[103:96] != data[103:96])
      $display("%0t: out_class expected %0d got %0d", $realtime, want[103:96],
               data[103:96]);
    if (want[104] != lst)
      $display("%0t: last expected %b got %b", $realtime, want[104], lst);
    if (want != {lst, data}) errors++;
  endfunction
endclass

module polyline_segment_to_hexagon_tb;
  import pst_pkg::*;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [71:0]  s_axis_tdata_i = '0;
  logic [1:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [103:0] m_axis_tdata_o;
  logic         m_axis_tlast_o;
  logic         psel_i = 0;
  logic         penable_i = 0;
  logic         pwrite_i = 0;
  logic [2:0]   paddr_i = '0;
  logic [31:0]  pwdata_i = '0;
  logic [31:0]  prdata_o;
  logic         pready_o;

  hex_scoreboard sb;
  bit no_idle;
  bit sink_calm;

  polyline_segment_to_hexagon dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("** polyline_segment_to_hexagon: FAILED **");
    $finish;
  end

  // sink with random stalls
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_corner(m_axis_tdata_o, m_axis_tlast_o);
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= sink_calm || no_idle || ($urandom_range(99) >= 26);
  end

  task automatic reg_write(int idx, bit [31:0] val);
    @(negedge clk_i);
    psel_i <= 1; pwrite_i <= 1; penable_i <= 0;
    paddr_i <= 3'(4 * idx); pwdata_i <= val;
    @(negedge clk_i);
    penable_i <= 1;
    @(posedge clk_i);
    @(negedge clk_i);
    psel_i <= 0; penable_i <= 0; pwrite_i <= 0;
    if (idx == CFG_TARGET_CLASS) sb.tgt_class = val[8:0];
    else sb.stroke_w = val;
  endtask

  task automatic send_vertex(bit [31:0] x, bit [31:0] y, bit [7:0] cls, bit first,
                             bit newex);
    while (!no_idle && $urandom_range(99) < 26) begin
      s_axis_tvalid_i <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= {cls, y, x};
    s_axis_tuser_i <= {newex, first};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_vertex(x, y, cls, first, newex);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  function automatic bit [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(400000)) - 200000);
      default: return 32'($signed($urandom_range(80)) - 40);
    endcase
  endfunction

  task automatic random_polyline(bit [7:0] tcls);
    int nv, mode;
    bit [7:0] cls;
    bit [31:0] bx, by;
    nv = $urandom_range(6, 2);
    mode = $urandom_range(9);
    mode = (mode < 2) ? 0 : (mode < 8) ? 1 : 2;
    cls = ($urandom_range(3) != 0) ? tcls : 8'($urandom());
    bx = rand_coord(mode == 0 ? 0 : 1);
    by = rand_coord(mode == 0 ? 0 : 1);
    send_vertex(bx, by, cls, 1, $urandom_range(7) == 0);
    for (int i = 1; i < nv; i++) begin
      if (mode == 2) begin
        bx = bx + rand_coord(2);
        by = by + rand_coord(2);
      end else begin
        bx = rand_coord(mode);
        by = rand_coord(mode);
      end
      send_vertex(bx, by, 8'($urandom()), 0, $urandom_range(1));
    end
  endtask

  initial begin
    int sent;
    bit [31:0] widths[4];
    sb = new();
    no_idle = 0;
    sink_calm = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1;
    // stray vertices before any polyline start, then passthrough at reset config
    send_vertex(32'h1234_5678, 32'h8000_0000, 8'hff, 0, 1);
    send_vertex(32'h7fff_ffff, 32'hffff_ffff, 8'h00, 1, 1);
    send_vertex(32'h0, 32'h1, 8'h00, 0, 0);
    drain();
    reg_write(CFG_TARGET_CLASS, 32'd7);
    send_vertex(32'h0, 32'h0, 8'd7, 1, 1);
    send_vertex(32'h0, 32'h0, 8'd7, 0, 0);
    send_vertex(32'h0000_0030, 32'h0000_0010, 8'd7, 0, 0);
    send_vertex(32'h0003_0000, 32'h0004_0000, 8'd7, 0, 0);
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 8'd7, 0, 0);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 8'd7, 0, 0);
    // line_width changes mid polyline at the extremes
    drain();
    reg_write(CFG_LINE_WIDTH, 32'hffff_ffff);
    send_vertex(32'h7fff_0000, 32'h8001_0000, 8'd3, 0, 1);
    drain();
    reg_write(CFG_LINE_WIDTH, 32'h0);
    send_vertex(32'h0010_0000, 32'hffe0_0000, 8'd3, 0, 0);
    send_vertex(32'h0000_0001, 32'h0000_0002, 8'd8, 1, 0);
    drain();
    reg_write(CFG_TARGET_CLASS, 32'h0000_00ff);
    reg_write(CFG_LINE_WIDTH, 32'h0002_8000);
    send_vertex(32'h0001_0000, 32'h0001_0000, 8'd255, 1, 1);
    send_vertex(32'hffff_0000, 32'h0001_0000, 8'd0, 0, 0);
    send_vertex(32'hffff_0000, 32'hfffe_0000, 8'd1, 0, 0);
    drain();
    widths = '{32'h0001_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0000_4000};
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      bit [7:0] tc;
      drain();
      tc = (ph == 5) ? 8'd0 : 8'($urandom());
      reg_write(CFG_TARGET_CLASS, (ph == 4) ? 32'h1ff : {24'd0, tc});
      reg_write(CFG_LINE_WIDTH, (ph < 4) ? widths[ph] : $urandom());
      no_idle = (ph == 2);
      sink_calm = (ph == 2);
      while (sent < (ph + 1) * 70) begin
        random_polyline(tc);
        sent = sent + 4;
        if (ph == 3 && $urandom_range(9) == 0) begin
          s_axis_tvalid_i <= 0;
          while (sb.pending.size() != 0) @(negedge clk_i);
        end
      end
    end
    no_idle = 0;
    sink_calm = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** polyline_segment_to_hexagon: PASSED **");
    end else begin
      $display("** polyline_segment_to_hexagon: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
